// File: src/gha_pkg.sv
package gha_pkg;

    localparam int SLOT_COUNT_DEF = 1024;
    localparam int GEN_BITS_DEF   = 16;
    localparam int MODE_W         = 2;
    localparam int COUNT_W        = 24;
    localparam int STATUS_W       = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_CREATE  = 2'd0,
        MODE_DESTROY = 2'd1,
        MODE_LOOKUP  = 2'd2
    } mode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_STACK,
        S_SLOT
    } state_t;

endpackage

// File: src/gha_ram.sv
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gha_ctrl.sv
module gha_ctrl #(
    parameter int SLOT_COUNT = 1024,
    parameter int GEN_BITS   = 16,
    localparam int SLOT_W  = $clog2(SLOT_COUNT),
    localparam int ENTRY_W = 1 + GEN_BITS + gha_pkg::COUNT_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gha_pkg::MODE_W-1:0]   mode,
    input  logic                         handle_present,
    input  logic [SLOT_W-1:0]            handle_slot,
    input  logic [GEN_BITS-1:0]          handle_gen,
    input  logic [gha_pkg::COUNT_W-1:0]  payload_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SLOT_W-1:0]            slot_out,
    output logic [GEN_BITS-1:0]          gen_out,
    output logic                         success,
    output logic [gha_pkg::COUNT_W-1:0]  count_out,
    output logic [gha_pkg::STATUS_W-1:0] status,
    output logic                         stack_we,
    output logic [SLOT_W-1:0]            stack_waddr,
    output logic [SLOT_W-1:0]            stack_wdata,
    output logic [SLOT_W-1:0]            stack_raddr,
    input  logic [SLOT_W-1:0]            stack_rdata,
    output logic                         tab_we,
    output logic [SLOT_W-1:0]            tab_waddr,
    output logic [ENTRY_W-1:0]           tab_wdata,
    output logic [SLOT_W-1:0]            tab_raddr,
    input  logic [ENTRY_W-1:0]           tab_rdata
);

    import gha_pkg::*;

    localparam int DEPTH_W = $clog2(SLOT_COUNT + 1);

    state_t                state_reg, state_next;
    logic [DEPTH_W-1:0]    depth_reg, depth_next;
    logic [DEPTH_W-1:0]    used_reg, used_next;
    logic [DEPTH_W-1:0]    depth_dec;

    logic [MODE_W-1:0]     mode_reg;
    logic                  present_reg;
    logic [SLOT_W-1:0]     hslot_reg;
    logic [GEN_BITS-1:0]   hgen_reg;
    logic [COUNT_W-1:0]    count_reg;
    logic [SLOT_W-1:0]     sel_slot_reg, sel_slot_next;

    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     slot_out_reg;
    logic [GEN_BITS-1:0]   gen_out_reg;
    logic                  success_reg;
    logic [COUNT_W-1:0]    count_out_reg;
    status_t               status_reg;

    logic [SLOT_W-1:0]     res_slot;
    logic [GEN_BITS-1:0]   res_gen;
    logic                  res_succ;
    logic [COUNT_W-1:0]    res_cnt;
    status_t               res_stat;

    logic                  accept;
    logic                  out_free;
    logic                  fire;
    logic                  reuse;
    logic                  match;
    logic                  rd_alive;
    logic [GEN_BITS-1:0]   rd_gen;
    logic [COUNT_W-1:0]    rd_cnt;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign fire     = (state_reg == S_SLOT) && out_free;

    assign depth_dec   = depth_reg - DEPTH_W'(1);
    assign stack_raddr = depth_dec[SLOT_W-1:0];

    assign reuse         = (mode_reg == MODE_CREATE) && (depth_reg != '0);
    assign sel_slot_next = reuse ? stack_rdata : hslot_reg;
    assign tab_raddr     = (state_reg == S_STACK) ? sel_slot_next : sel_slot_reg;

    assign {rd_alive, rd_gen, rd_cnt} = tab_rdata;

    assign match = present_reg && (DEPTH_W'(hslot_reg) < used_reg) && rd_alive
                   && (rd_gen == hgen_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            used_reg      <= used_next;
            out_valid_reg <= fire || (out_valid_reg && !out_ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg    <= mode;
            present_reg <= handle_present;
            hslot_reg   <= handle_slot;
            hgen_reg    <= handle_gen;
            count_reg   <= payload_count;
        end
        if (state_reg == S_STACK)
        begin
            sel_slot_reg <= sel_slot_next;
        end
        if (fire)
        begin
            slot_out_reg  <= res_slot;
            gen_out_reg   <= res_gen;
            success_reg   <= res_succ;
            count_out_reg <= res_cnt;
            status_reg    <= res_stat;
        end
    end

    always_comb
    begin
        logic tab_wr;
        logic stack_wr;
        logic [DEPTH_W-1:0] depth_upd;
        logic [DEPTH_W-1:0] used_upd;

        res_slot    = '0;
        res_gen     = '0;
        res_succ    = 1'b0;
        res_cnt     = '0;
        res_stat    = ST_INVALID;
        tab_wr      = 1'b0;
        stack_wr    = 1'b0;
        tab_waddr   = sel_slot_reg;
        tab_wdata   = {1'b1, rd_gen, count_reg};
        stack_waddr = depth_reg[SLOT_W-1:0];
        stack_wdata = hslot_reg;
        depth_upd   = depth_reg;
        used_upd    = used_reg;

        case (mode_t'(mode_reg))
            MODE_CREATE:
            begin
                if (count_reg == '0)
                begin
                    res_stat = ST_EMPTY;
                end
                else if (depth_reg != '0)
                begin
                    res_slot  = sel_slot_reg;
                    res_gen   = rd_gen;
                    res_succ  = 1'b1;
                    res_stat  = ST_OK;
                    tab_wr    = 1'b1;
                    depth_upd = depth_dec;
                end
                else if (used_reg < DEPTH_W'(SLOT_COUNT))
                begin
                    res_slot  = used_reg[SLOT_W-1:0];
                    res_succ  = 1'b1;
                    res_stat  = ST_OK;
                    tab_wr    = 1'b1;
                    tab_waddr = used_reg[SLOT_W-1:0];
                    tab_wdata = {1'b1, {GEN_BITS{1'b0}}, count_reg};
                    used_upd  = used_reg + DEPTH_W'(1);
                end
                else
                begin
                    res_stat = ST_FULL;
                end
            end
            MODE_DESTROY:
            begin
                res_slot = hslot_reg;
                if (match && (depth_reg < DEPTH_W'(SLOT_COUNT)))
                begin
                    res_succ  = 1'b1;
                    res_stat  = ST_OK;
                    tab_wr    = 1'b1;
                    tab_waddr = hslot_reg;
                    tab_wdata = {1'b0, rd_gen + GEN_BITS'(1), rd_cnt};
                    stack_wr  = 1'b1;
                    depth_upd = depth_reg + DEPTH_W'(1);
                end
            end
            MODE_LOOKUP:
            begin
                res_slot = hslot_reg;
                if (match)
                begin
                    if (rd_cnt == '0)
                    begin
                        res_stat = ST_EMPTY;
                    end
                    else
                    begin
                        res_cnt  = rd_cnt;
                        res_succ = 1'b1;
                        res_stat = ST_OK;
                    end
                end
            end
            default:
            begin
                res_stat = ST_INVALID;
            end
        endcase

        tab_we     = fire && tab_wr;
        stack_we   = fire && stack_wr;
        depth_next = fire ? depth_upd : depth_reg;
        used_next  = fire ? used_upd : used_reg;

        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_STACK;
                end
            end
            S_STACK:
            begin
                state_next = S_SLOT;
            end
            S_SLOT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign slot_out  = slot_out_reg;
    assign gen_out   = gen_out_reg;
    assign success   = success_reg;
    assign count_out = count_out_reg;
    assign status    = status_reg;

endmodule

// File: src/generational_handle_allocator.sv
// An accepted beat steps through S_STACK and S_SLOT; its result is registered as it leaves S_SLOT.
// A new beat is taken only in S_IDLE, once the last one is through, as it needs two dependent reads
// (free stack, then slot table), each of them a registered read.
// A waiting result does not stop the next input beat being accepted, but holds that beat in S_SLOT.
// Reset (async, active low) empties the free stack and the slot count; the
// memories are not cleared and are read only at entries written before.
module generational_handle_allocator #(
    parameter int SLOT_COUNT = gha_pkg::SLOT_COUNT_DEF,
    parameter int GEN_BITS   = gha_pkg::GEN_BITS_DEF,
    localparam int SLOT_W    = $clog2(SLOT_COUNT)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [gha_pkg::MODE_W-1:0]   mode,
    input  logic                         handle_present,
    input  logic [SLOT_W-1:0]            handle_slot,
    input  logic [GEN_BITS-1:0]          handle_gen,
    input  logic [gha_pkg::COUNT_W-1:0]  payload_count,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [SLOT_W-1:0]            slot_out,
    output logic [GEN_BITS-1:0]          gen_out,
    output logic                         success,
    output logic [gha_pkg::COUNT_W-1:0]  count_out,
    output logic [gha_pkg::STATUS_W-1:0] status
);

    import gha_pkg::*;

    localparam int ENTRY_W = 1 + GEN_BITS + COUNT_W;

    logic                stack_we;
    logic [SLOT_W-1:0]   stack_waddr;
    logic [SLOT_W-1:0]   stack_wdata;
    logic [SLOT_W-1:0]   stack_raddr;
    logic [SLOT_W-1:0]   stack_rdata;
    logic                tab_we;
    logic [SLOT_W-1:0]   tab_waddr;
    logic [ENTRY_W-1:0]  tab_wdata;
    logic [SLOT_W-1:0]   tab_raddr;
    logic [ENTRY_W-1:0]  tab_rdata;

    gha_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOT_COUNT)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    gha_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    gha_ctrl #(
        .SLOT_COUNT (SLOT_COUNT),
        .GEN_BITS   (GEN_BITS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .mode           (mode),
        .handle_present (handle_present),
        .handle_slot    (handle_slot),
        .handle_gen     (handle_gen),
        .payload_count  (payload_count),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .slot_out       (slot_out),
        .gen_out        (gen_out),
        .success        (success),
        .count_out      (count_out),
        .status         (status),
        .stack_we       (stack_we),
        .stack_waddr    (stack_waddr),
        .stack_wdata    (stack_wdata),
        .stack_raddr    (stack_raddr),
        .stack_rdata    (stack_rdata),
        .tab_we         (tab_we),
        .tab_waddr      (tab_waddr),
        .tab_wdata      (tab_wdata),
        .tab_raddr      (tab_raddr),
        .tab_rdata      (tab_rdata)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while previous beat still in flight");

    a_push_with_retire: assert property (@(posedge clk) disable iff (!rst_n)
        stack_we |-> (tab_we && (tab_waddr == stack_wdata)))
        else $error("free stack push without matching slot retire");

    a_write_means_success: assert property (@(posedge clk) disable iff (!rst_n)
        tab_we |=> (out_valid && success && (status == ST_OK)))
        else $error("slot table written without a successful result");

    a_no_write_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !(tab_we || stack_we))
        else $error("memory write while idle");

endmodule
